// ===== hdl/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// shared types and constants of the sinusoidal segment crossfade
// ----------------------------------------------------------------------------
package ssc_pkg;

	// sample and weight widths
	localparam int SAMPLE_BITS = 16;
	localparam int WGT_W       = 17;                 // weights 0..32768, unsigned
	localparam int PROD_W      = SAMPLE_BITS + WGT_W + 1;
	localparam int SUM_W       = PROD_W + 1;

	// configuration port
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEGMENT_LENGTH = 3'd0,
		REG_SPLICE_START   = 3'd1,
		REG_SPLICE_COUNT   = 3'd2,
		REG_LEFT_OVERLAP   = 3'd3,
		REG_RISING_STEP    = 3'd4,
		REG_FALLING_STEP   = 3'd5
	} cfg_reg_t;

	// reset values of the registers
	localparam logic [CFG_W-1:0] RST_SEGMENT_LENGTH = 24'd1024;
	localparam logic [CFG_W-1:0] RST_SPLICE_START   = 24'd512;
	localparam logic [CFG_W-1:0] RST_SPLICE_COUNT   = 24'd0;
	localparam logic [CFG_W-1:0] RST_LEFT_OVERLAP   = 24'd512;
	localparam logic [CFG_W-1:0] RST_RISING_STEP    = 24'd32768;
	localparam logic [CFG_W-1:0] RST_FALLING_STEP   = 24'd32768;

	localparam logic [CFG_W-1:0] INDEX_MAX = {CFG_W{1'b1}};

	// quarter turn of phase in q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] long_sample;
		logic signed [SAMPLE_BITS-1:0] short_sample;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mixed_sample;
		logic                          in_splice;
	} result_t;

	// first pipeline stage, handed from control to the mixer
	typedef struct packed {
		logic                          valid;
		logic signed [SAMPLE_BITS-1:0] long_sample;
		logic signed [SAMPLE_BITS-1:0] short_sample;
		logic                          in_region;
		logic                          rising;
	} stage1_t;

endpackage

// ===== hdl/sinusoidal_segment_crossfade.sv =====
// ----------------------------------------------------------------------------
// sinusoidal_segment_crossfade
// sine/cosine crossfade of a long and a short segment train over a splice
// ----------------------------------------------------------------------------
// usage
//   input channel: sample_valid / sample_stall, one beat per output index,
//   carrying the long train sample and the time-aligned short train sample.
//   result channel: result_valid / result_stall, one beat per input beat,
//   in order, with the mixed sample and the in-splice flag.
//   config channel: cfg_valid / cfg_ready, index and data; cfg_ready is
//   always high. write only while no beat is in flight.
// timing
//   one beat per cycle while result_stall is low; result_valid rises once
//   the beat has passed the input and table register, the product register,
//   then round and saturate into the result register. the rate is set by the
//   table's two read ports, used once per beat.
// reset
//   arst_n clears the counters, the phase and the pipeline valids, and loads
//   the register defaults; the weight table is constant and needs no pass.
// stall
//   a stalled result holds in the result register; earlier stages keep
//   filling their empty slots, and sample_stall rises only once all are full.
// ----------------------------------------------------------------------------
module sinusoidal_segment_crossfade #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ssc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ssc_pkg::CFG_W-1:0]           cfg_data,
	// input samples
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  ssc_pkg::sample_t                    sample,
	// results
	output logic                                result_valid,
	input  logic                                result_stall,
	output ssc_pkg::result_t                    result
);

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH+1);

	logic                       rom_rd;
	logic [IDX_W-1:0]           sin_addr;
	logic [IDX_W-1:0]           cos_addr;
	logic [ssc_pkg::WGT_W-1:0]  sin_w_s1;
	logic [ssc_pkg::WGT_W-1:0]  cos_w_s1;
	ssc_pkg::stage1_t           s1;
	logic                       s1_take;
	logic                       cfg_wr;

	// registers are plain flops, a write is always accepted
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// counters, phase and region decode; feeds the table address
	ssc_ctrl #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_wr),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.rom_rd       (rom_rd),
		.sin_addr     (sin_addr),
		.cos_addr     (cos_addr),
		.s1           (s1),
		.s1_take      (s1_take)
	);

	// sine at the phase index, cosine at the mirrored index
	ssc_rom #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk      (clk),
		.rd_en    (rom_rd),
		.sin_addr (sin_addr),
		.cos_addr (cos_addr),
		.sin_w_s1 (sin_w_s1),
		.cos_w_s1 (cos_w_s1)
	);

	// two products, then sum, round, saturate into the result register
	ssc_mix u_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1           (s1),
		.sin_w_s1     (sin_w_s1),
		.cos_w_s1     (cos_w_s1),
		.s1_take      (s1_take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== hdl/ssc_rom.sv =====
// ----------------------------------------------------------------------------
// ssc_rom
// quarter-sine weight table with two registered read ports
// ----------------------------------------------------------------------------
module ssc_rom #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    rd_en,
	input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]   sin_addr,
	input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]   cos_addr,
	output logic [ssc_pkg::WGT_W-1:0]               sin_w_s1,
	output logic [ssc_pkg::WGT_W-1:0]               cos_w_s1
);

	// round(2^15 * sin(pi/2 * k / depth)) by an integer q30 taylor series
	function automatic logic [ssc_pkg::WGT_W-1:0] sine_entry(input int unsigned k);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        w;
		logic signed [63:0] sum;
		x    = (ssc_pkg::HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		term = ((term * x2) >> 30) / 6;   sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 20;  sum = sum + signed'(term);
		term = ((term * x2) >> 30) / 42;  sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 72;  sum = sum + signed'(term);
		term = ((term * x2) >> 30) / 110; sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 156; sum = sum + signed'(term);
		term = ((term * x2) >> 30) / 210; sum = sum - signed'(term);
		if (sum < 0) begin
			sum = 0;
		end
		w = (unsigned'(sum) + 64'd16384) >> 15;
		if (w > 64'd32768) begin
			w = 64'd32768;
		end
		return ssc_pkg::WGT_W'(w);
	endfunction

	logic [ssc_pkg::WGT_W-1:0] rom [SINE_TABLE_DEPTH+1];

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		assign rom[k] = sine_entry(k);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			sin_w_s1 <= rom[sin_addr];
			cos_w_s1 <= rom[cos_addr];
		end
	end

endmodule

// ===== hdl/ssc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssc_ctrl
// configuration registers, sample and segment counters, phase accumulator
// and the first pipeline stage
// ----------------------------------------------------------------------------
module ssc_ctrl #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration writes
	input  logic                                    cfg_wr,
	input  logic [ssc_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [ssc_pkg::CFG_W-1:0]               cfg_data,
	// input channel
	input  logic                                    sample_valid,
	output logic                                    sample_stall,
	input  ssc_pkg::sample_t                        sample,
	// to the table and the mixer
	output logic                                    rom_rd,
	output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]   sin_addr,
	output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]   cos_addr,
	output ssc_pkg::stage1_t                        s1,
	input  logic                                    s1_take
);

	localparam int W     = ssc_pkg::CFG_W;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH+1);

	logic [W-1:0] segment_length_q;
	logic [W-1:0] splice_start_q;
	logic [W-1:0] splice_count_q;
	logic [W-1:0] left_overlap_q;
	logic [W-1:0] rising_step_q;
	logic [W-1:0] falling_step_q;

	logic [W-1:0] sample_index_q;
	logic [W-1:0] segment_position_q;
	logic [W-1:0] phase_q;

	logic                 en1;
	logic                 accept;
	logic [W:0]           region_end;
	logic                 in_region;
	logic                 rising;
	logic [W+IDX_W-1:0]   idx_prod;
	logic [IDX_W-1:0]     idx;
	logic [W:0]           pos_inc;
	logic [W-1:0]         next_pos;
	logic [W-1:0]         next_phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_length_q <= ssc_pkg::RST_SEGMENT_LENGTH;
			splice_start_q   <= ssc_pkg::RST_SPLICE_START;
			splice_count_q   <= ssc_pkg::RST_SPLICE_COUNT;
			left_overlap_q   <= ssc_pkg::RST_LEFT_OVERLAP;
			rising_step_q    <= ssc_pkg::RST_RISING_STEP;
			falling_step_q   <= ssc_pkg::RST_FALLING_STEP;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				ssc_pkg::REG_SEGMENT_LENGTH: segment_length_q <= cfg_data;
				ssc_pkg::REG_SPLICE_START:   splice_start_q   <= cfg_data;
				ssc_pkg::REG_SPLICE_COUNT:   splice_count_q   <= cfg_data;
				ssc_pkg::REG_LEFT_OVERLAP:   left_overlap_q   <= cfg_data;
				ssc_pkg::REG_RISING_STEP:    rising_step_q    <= cfg_data;
				ssc_pkg::REG_FALLING_STEP:   falling_step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves when empty or when the mixer takes it
	assign en1          = !s1.valid || s1_take;
	assign sample_stall = !en1;
	assign accept       = sample_valid && en1;
	assign rom_rd       = accept;

	// region end kept one bit wider so a large end never wraps
	assign region_end = {1'b0, splice_start_q} + {1'b0, splice_count_q};
	assign in_region  = (sample_index_q >= splice_start_q) &&
	                    ({1'b0, sample_index_q} < region_end);
	assign rising     = segment_position_q < left_overlap_q;

	// table index from the top bits of phase times depth
	assign idx_prod = (W+IDX_W)'(phase_q) * (W+IDX_W)'(SINE_TABLE_DEPTH);
	assign idx      = idx_prod[W +: IDX_W];
	assign sin_addr = idx;
	assign cos_addr = IDX_W'(SINE_TABLE_DEPTH) - idx;

	// position wraps at the segment boundary, phase restarts there and at the
	// rising to falling change
	always_comb begin
		pos_inc  = {1'b0, segment_position_q} + (W+1)'(1);
		next_pos = (pos_inc >= {1'b0, segment_length_q}) ? '0 : pos_inc[W-1:0];
		priority if (next_pos == '0 || next_pos == left_overlap_q) begin
			next_phase = '0;
		end else if (next_pos < left_overlap_q) begin
			next_phase = phase_q + rising_step_q;
		end else begin
			next_phase = phase_q + falling_step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q     <= '0;
			segment_position_q <= '0;
			phase_q            <= '0;
			s1                 <= '0;
		end else begin
			if (en1) begin
				s1.valid <= sample_valid;
			end
			if (accept) begin
				segment_position_q <= next_pos;
				phase_q            <= next_phase;
				if (sample_index_q != ssc_pkg::INDEX_MAX) begin
					sample_index_q <= sample_index_q + W'(1);
				end
				s1.long_sample  <= sample.long_sample;
				s1.short_sample <= sample.short_sample;
				s1.in_region    <= in_region;
				s1.rising       <= rising;
			end
		end
	end

endmodule

// ===== hdl/ssc_mix.sv =====
// ----------------------------------------------------------------------------
// ssc_mix
// weighted sum of the two samples, rounding, saturation and result register
// ----------------------------------------------------------------------------
module ssc_mix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ssc_pkg::stage1_t            s1,
	input  logic [ssc_pkg::WGT_W-1:0]   sin_w_s1,
	input  logic [ssc_pkg::WGT_W-1:0]   cos_w_s1,
	output logic                        s1_take,
	output logic                        result_valid,
	input  logic                        result_stall,
	output ssc_pkg::result_t            result
);

	localparam int SB = ssc_pkg::SAMPLE_BITS;
	localparam int PW = ssc_pkg::PROD_W;
	localparam int SW = ssc_pkg::SUM_W;

	localparam logic signed [SW-1:0] HALF_LSB = SW'(16384);
	localparam logic signed [SW-1:0] SAT_HI   = SW'((64'd1 << (SB-1)) - 64'd1);
	localparam logic signed [SW-1:0] SAT_LO   = -SAT_HI - SW'(1);

	logic                          valid_s2;
	logic signed [PW-1:0]          prod_a_s2;
	logic signed [PW-1:0]          prod_b_s2;
	logic signed [SB-1:0]          long_s2;
	logic                          inside_s2;
	logic                          valid_s3;

	logic                          en2;
	logic                          en3;
	logic [ssc_pkg::WGT_W-1:0]     w_a;
	logic [ssc_pkg::WGT_W-1:0]     w_b;
	logic signed [PW-1:0]          prod_a;
	logic signed [PW-1:0]          prod_b;
	logic signed [SW-1:0]          sum_r;
	logic signed [SW-1:0]          shifted;
	logic signed [SB-1:0]          mixed;

	assign en3     = !valid_s3 || !result_stall;
	assign en2     = !valid_s2 || en3;
	assign s1_take = en2;

	// rising part weights long by sine, falling part by cosine
	assign w_a    = s1.rising ? sin_w_s1 : cos_w_s1;
	assign w_b    = s1.rising ? cos_w_s1 : sin_w_s1;
	assign prod_a = PW'(s1.long_sample)  * PW'(signed'({1'b0, w_a}));
	assign prod_b = PW'(s1.short_sample) * PW'(signed'({1'b0, w_b}));

	// round half up, then clamp to the sample range
	always_comb begin
		sum_r   = SW'(prod_a_s2) + SW'(prod_b_s2) + HALF_LSB;
		shifted = sum_r >>> 15;
		priority if (shifted > SAT_HI) begin
			mixed = SAT_HI[SB-1:0];
		end else if (shifted < SAT_LO) begin
			mixed = SAT_LO[SB-1:0];
		end else begin
			mixed = shifted[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en2) begin
				valid_s2 <= s1.valid;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && s1.valid) begin
			prod_a_s2 <= prod_a;
			prod_b_s2 <= prod_b;
			long_s2   <= s1.long_sample;
			inside_s2 <= s1.in_region;
		end
		if (en3 && valid_s2) begin
			result.mixed_sample <= inside_s2 ? mixed : long_s2;
			result.in_splice    <= inside_s2;
		end
	end

	assign result_valid = valid_s3;

endmodule
